// ----- src/buddy_frame_allocator_assert.svh -----
// Assertion macros for the buddy frame allocator.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef BUDDY_FRAME_ALLOCATOR_ASSERT_SVH
`define BUDDY_FRAME_ALLOCATOR_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BFA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a trigger implies a condition in the next cycle.
`define BFA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- src/bfa_pkg.sv -----
// Shared types and constants for the buddy frame allocator.
// No dependencies.
`default_nettype none

package bfa_pkg;
  localparam int unsigned FRAME_COUNT_DEF = 1024;
  localparam int unsigned ORDER_SLOTS = 16;
  localparam logic [3:0] TOP_ORDER_RESET = 4'd10;

  typedef logic [3:0] order_t;
  typedef logic [9:0] frame_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;
endpackage

`default_nettype wire

// ----- src/buddy_frame_allocator.sv -----
// Buddy frame allocator: request sequencer, free lists and pair bits.
// Depends on bfa_pkg and buddy_frame_allocator_assert.svh.
//
// A request is taken when start is high and busy is low. Its one result word
// appears on ok and granted_index for exactly one cycle with done, and busy
// falls in that same cycle, so the next request can be taken at the edge that
// ends it. The receiver cannot stall. After reset, busy stays high while the
// pair-bit memory is cleared. A bad order or a bad free is answered from idle
// without leaving it. A free merges with free buddies until it finds none or
// one that is not free. An allocate looks at the orders from the one asked
// for up to the one that holds a block, then splits that block down, and
// fails if it finds nothing up to top_order.
`default_nettype none

module buddy_frame_allocator #(
  parameter int unsigned FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire logic           mode,
  input  wire bfa_pkg::order_t order,
  input  wire bfa_pkg::frame_t frame_index,
  input  wire logic           cfg_we,
  input  wire bfa_pkg::order_t cfg_wdata,
  output logic                done,
  output logic                ok,
  output bfa_pkg::frame_t     granted_index
);
  import bfa_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_COUNT);
  localparam int unsigned LW = AW + 1;
  localparam logic [LW-1:0] NONE = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_URD, S_UWR, S_FRD, S_FWR, S_FTEST, S_SPLIT, S_APP1, S_APP2,
    S_CLEAR
  } state_t;

  state_t state;
  order_t top_order;
  logic is_free;
  order_t req_order;
  logic [4:0] lvl;
  logic [AW-1:0] base;
  logic [AW-1:0] node;
  logic [AW-1:0] clr_addr;
  logic [LW-1:0] head [ORDER_SLOTS];
  logic [LW-1:0] tail [ORDER_SLOTS];

  logic [LW-1:0] next_mem [FRAME_COUNT];
  logic [LW-1:0] prev_mem [FRAME_COUNT];
  logic pair_mem [FRAME_COUNT];
  logic [LW-1:0] next_rd;
  logic [LW-1:0] prev_rd;
  logic pair_rd;

  logic next_we, prev_we, pair_we;
  logic [AW-1:0] next_wa, prev_wa, pair_addr, pair_wa;
  logic [LW-1:0] next_wd, prev_wd;
  logic pair_wd;
  logic [31:0] pair_sum;
  logic [LW-1:0] tail_cur;

  function automatic logic valid_link(input logic [LW-1:0] v);
    return 32'(v) < FRAME_COUNT;
  endfunction

  function automatic logic has_buddy(input logic [AW-1:0] idx, input logic [4:0] o,
                                     input order_t top);
    logic [31:0] b;
    b = (32'(idx) ^ (32'd1 << o)) + (32'd1 << o);
    return (o < 5'(top)) && (b <= FRAME_COUNT);
  endfunction

  assign busy = (state != S_IDLE);
  assign tail_cur = tail[lvl[3:0]];
  assign pair_sum = (32'(FRAME_COUNT) >> (lvl + 5'd1)) + (32'(node) >> (lvl + 5'd1));
  assign pair_addr = pair_sum[AW-1:0];

  always_comb begin
    next_we = 1'b0;
    next_wa = node;
    next_wd = NONE;
    prev_we = 1'b0;
    prev_wa = node;
    prev_wd = tail_cur;
    pair_we = (state == S_FWR) || (state == S_CLEAR);
    pair_wa = (state == S_CLEAR) ? clr_addr : pair_addr;
    pair_wd = (state == S_CLEAR) ? 1'b0 : ~pair_rd;
    case (state)
      S_UWR: begin
        next_we = valid_link(prev_rd);
        next_wa = prev_rd[AW-1:0];
        next_wd = next_rd;
        prev_we = valid_link(next_rd);
        prev_wa = next_rd[AW-1:0];
        prev_wd = prev_rd;
      end
      S_APP1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      S_APP2: begin
        next_we = valid_link(tail_cur);
        next_wa = tail_cur[AW-1:0];
        next_wd = LW'(node);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    next_rd <= next_mem[node];
    prev_rd <= prev_mem[node];
    pair_rd <= pair_mem[pair_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      top_order <= TOP_ORDER_RESET;
      done <= 1'b0;
      ok <= 1'b0;
      granted_index <= '0;
      for (int k = 0; k < ORDER_SLOTS; k++) begin
        head[k] <= NONE;
        tail[k] <= NONE;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        top_order <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(FRAME_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            is_free <= (mode == MODE_FREE);
            req_order <= order;
            lvl <= 5'(order);
            base <= AW'(32'(frame_index));
            if (order > top_order) begin
              done <= 1'b1;
              ok <= 1'b0;
              granted_index <= '0;
            end else if (mode == MODE_ALLOC) begin
              state <= S_SCAN;
            end else if (((32'(frame_index) & ((32'd1 << order) - 32'd1)) != 32'd0) ||
                         (32'(frame_index) + (32'd1 << order) > FRAME_COUNT)) begin
              done <= 1'b1;
              ok <= 1'b0;
              granted_index <= '0;
            end else begin
              state <= S_FTEST;
            end
          end
        end
        S_SCAN: begin
          if (lvl > 5'(top_order)) begin
            done <= 1'b1;
            ok <= 1'b0;
            granted_index <= '0;
            state <= S_IDLE;
          end else if (valid_link(head[lvl[3:0]])) begin
            base <= head[lvl[3:0]][AW-1:0];
            node <= head[lvl[3:0]][AW-1:0];
            state <= S_URD;
          end else begin
            lvl <= lvl + 5'd1;
          end
        end
        S_URD: begin
          state <= S_UWR;
        end
        S_UWR: begin
          if (!valid_link(prev_rd)) begin
            head[lvl[3:0]] <= next_rd;
          end
          if (!valid_link(next_rd)) begin
            tail[lvl[3:0]] <= prev_rd;
          end
          if (is_free) begin
            lvl <= lvl + 5'd1;
            if (node < base) begin
              base <= node;
            end
            state <= S_FTEST;
          end else if (has_buddy(base, lvl, top_order)) begin
            node <= base;
            state <= S_FRD;
          end else begin
            state <= S_SPLIT;
          end
        end
        S_FRD: begin
          state <= S_FWR;
        end
        S_FWR: begin
          if (!is_free) begin
            state <= S_SPLIT;
          end else if (!pair_rd) begin
            node <= base;
            state <= S_APP1;
          end else begin
            state <= S_URD;
          end
        end
        S_FTEST: begin
          if (has_buddy(base, lvl, top_order)) begin
            node <= AW'(32'(base) ^ (32'd1 << lvl));
            state <= S_FRD;
          end else begin
            node <= base;
            state <= S_APP1;
          end
        end
        S_SPLIT: begin
          if (lvl > 5'(req_order)) begin
            lvl <= lvl - 5'd1;
            node <= AW'(32'(base) + (32'd1 << (lvl - 5'd1)));
            state <= S_APP1;
          end else begin
            done <= 1'b1;
            ok <= 1'b1;
            granted_index <= frame_t'(32'(base));
            state <= S_IDLE;
          end
        end
        S_APP1: begin
          state <= S_APP2;
        end
        S_APP2: begin
          if (!valid_link(tail_cur)) begin
            head[lvl[3:0]] <= LW'(node);
          end
          tail[lvl[3:0]] <= LW'(node);
          if (is_free) begin
            done <= 1'b1;
            ok <= 1'b1;
            granted_index <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_FRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "buddy_frame_allocator_assert.svh"

  `BFA_ASSERT_ALWAYS(a_done_idle, !done || !busy, "result word while busy")
  `BFA_ASSERT_NEXT(a_start_ack, start && !busy, done || busy, "request neither run nor answered")
  `BFA_ASSERT_ALWAYS(a_fail_zero, !done || ok || granted_index == '0, "failed word has index")
  `BFA_ASSERT_NEXT(a_busy_end, busy && (state != S_CLEAR), busy || done, "busy dropped without result")

endmodule

`default_nettype wire

// ----- bench/tb_buddy_frame_allocator.sv -----
// Self-checking testbench for the buddy frame allocator: drives allocate and free
// requests, predicts each result word with its own free-list model and compares.
// Depends on bfa_pkg and the buddy_frame_allocator RTL.
`default_nettype none

module tb_buddy_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  localparam int unsigned NFR = 1024;
  localparam int unsigned EMPTY = 32'hFFFF_FFFF;

  typedef struct packed {
    logic   ok;
    frame_t idx;
  } grant_t;

  typedef struct {
    int unsigned idx;
    int unsigned ord;
  } block_t;

  class grant_board;
    grant_t pending[$];
    int     errors;
    int     checked;

    function void note(grant_t g);
      pending.push_back(g);
    endfunction

    function void check(logic ok, frame_t idx);
      grant_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected word: ok=%0b index=%0d", ok, idx);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.ok !== ok || want.idx !== idx) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected ok=%0b index=%0d, got ok=%0b index=%0d",
                   want.ok, want.idx, ok, idx);
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   mode = MODE_ALLOC;
  order_t order = '0;
  frame_t frame_index = '0;
  logic   cfg_we = 1'b0;
  order_t cfg_wdata = '0;
  logic   busy, done, ok;
  frame_t granted_index;

  buddy_frame_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .order(order),
    .frame_index(frame_index), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .ok(ok), .granted_index(granted_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Free-list model state.
  int unsigned top_ord;
  int unsigned head_q[16];
  int unsigned tail_q[16];
  int unsigned next_lk[NFR];
  int unsigned prev_lk[NFR];
  bit          pair_bit[16][NFR];

  // Stimulus bookkeeping: 0 never used, 1 free, 2 granted.
  byte         frame_use[NFR];
  block_t      granted[$];
  grant_board  board = new();
  bit          no_gaps;
  int          n_items, n_grants;

  function automatic void list_push(int unsigned o, int unsigned n);
    if (n >= NFR) return;
    next_lk[n] = EMPTY;
    prev_lk[n] = tail_q[o];
    if (tail_q[o] < NFR) next_lk[tail_q[o]] = n;
    else head_q[o] = n;
    tail_q[o] = n;
  endfunction

  function automatic void list_drop(int unsigned o, int unsigned n);
    int unsigned p, q;
    if (n >= NFR) return;
    p = prev_lk[n];
    q = next_lk[n];
    if (p < NFR) next_lk[p] = q;
    else head_q[o] = q;
    if (q < NFR) prev_lk[q] = p;
    else tail_q[o] = p;
  endfunction

  function automatic bit pair_toggle(int unsigned n, int unsigned o);
    if (n >= NFR) return 1'b1;
    pair_bit[o][n >> (o + 1)] ^= 1'b1;
    return pair_bit[o][n >> (o + 1)];
  endfunction

  function automatic bit has_pair(int unsigned n, int unsigned o);
    return o < top_ord && ((n ^ (1 << o)) + (1 << o)) <= NFR;
  endfunction

  function automatic grant_t serve_request(logic m, int unsigned o, int unsigned f);
    grant_t r;
    int unsigned i, left, bud;
    r = '0;
    if (o > top_ord) return r;
    if (m == MODE_ALLOC) begin
      left = EMPTY;
      for (i = o; i <= top_ord; i++) begin
        if (head_q[i] < NFR) begin
          left = head_q[i];
          break;
        end
      end
      if (left == EMPTY) return r;
      list_drop(i, left);
      if (has_pair(left, i)) void'(pair_toggle(left, i));
      while (i > o) begin
        i--;
        list_push(i, left + (1 << i));
        void'(pair_toggle(left + (1 << i), i));
      end
      r.ok = 1'b1;
      r.idx = left[9:0];
      return r;
    end
    if ((f & ((1 << o) - 1)) != 0 || f + (1 << o) > NFR) return r;
    i = o;
    while (i < top_ord) begin
      if (!has_pair(f, i)) break;
      bud = f ^ (1 << i);
      if (pair_toggle(bud, i)) break;
      list_drop(i, bud);
      i++;
      if (bud < f) f = bud;
    end
    list_push(i, f);
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic void mark(int unsigned f, int unsigned o, byte v);
    for (int unsigned k = f; k < f + (1 << o) && k < NFR; k++) frame_use[k] = v;
  endfunction

  task automatic request(input logic m, input int unsigned o, input int unsigned f,
                         output grant_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk);
    @(negedge clk);
    start <= 1'b1;
    mode <= m;
    order <= o[3:0];
    frame_index <= f[9:0];
    r = serve_request(m, o, f);
    board.note(r);
    n_items++;
    if (r.ok && m == MODE_ALLOC) begin
      mark(r.idx, o, 2);
      granted.push_back('{r.idx, o});
      n_grants++;
    end else if (r.ok) begin
      mark(f, o, 1);
    end
    while (busy) @(negedge clk);
    @(negedge clk);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_top(input int unsigned v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    top_ord = v;
  endtask

  // Hand out every free block so the next setting starts from clean pair bits.
  task automatic drain;
    grant_t r;
    for (int o = int'(top_ord); o >= 0; o--) begin
      do request(MODE_ALLOC, o, $urandom_range(0, 1023), r);
      while (r.ok);
    end
    granted.delete();
  endtask

  task automatic random_phase(input int count);
    grant_t r;
    int unsigned pick, o, f, k;
    bit found;
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
      pick = $urandom_range(0, 99);
      o = $urandom_range(0, top_ord);
      if (pick < 35) begin
        found = 1'b0;
        for (int t = 0; t < 12 && !found; t++) begin
          f = ($urandom_range(0, 1023) >> o) << o;
          found = 1'b1;
          for (k = f; k < f + (1 << o); k++) if (frame_use[k] != 0) found = 1'b0;
        end
        if (found) request(MODE_FREE, o, f, r);
        else request(MODE_ALLOC, o, $urandom_range(0, 1023), r);
      end else if (pick < 70) begin
        request(MODE_ALLOC, o, $urandom_range(0, 1023), r);
      end else if (pick < 90 && granted.size() != 0) begin
        k = $urandom_range(0, granted.size() - 1);
        f = granted[k].idx;
        o = granted[k].ord;
        granted.delete(k);
        request(MODE_FREE, o, f, r);
      end else if (pick < 95) begin
        o = $urandom_range(1, 10);
        f = $urandom_range(0, 1023) | (1 << $urandom_range(0, o - 1));
        request(MODE_FREE, o, f, r);
      end else begin
        request($urandom_range(0, 1), $urandom_range(top_ord + 1, 15),
                $urandom_range(0, 1023), r);
      end
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && done) board.check(ok, granted_index);
  end

  initial begin
    grant_t r;
    top_ord = TOP_ORDER_RESET;
    foreach (head_q[o]) begin
      head_q[o] = EMPTY;
      tail_q[o] = EMPTY;
    end
    foreach (frame_use[k]) begin
      frame_use[k] = 0;
      next_lk[k] = 0;
      prev_lk[k] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    no_gaps = 1'b0;
    request(MODE_ALLOC, 15, 1023, r);
    request(MODE_FREE, 11, 0, r);
    request(MODE_ALLOC, 0, 0, r);
    request(MODE_FREE, 1, 1023, r);
    request(MODE_FREE, 10, 512, r);
    request(MODE_FREE, 0, 1023, r);
    request(MODE_FREE, 0, 1022, r);
    request(MODE_ALLOC, 0, 1023, r);
    request(MODE_ALLOC, 0, 0, r);
    request(MODE_FREE, 0, 1023, r);
    request(MODE_FREE, 0, 1022, r);
    request(MODE_FREE, 2, 1016, r);
    request(MODE_ALLOC, 3, 0, r);
    request(MODE_ALLOC, 1, 0, r);
    drain();

    set_top(1);
    random_phase(110);
    set_top(4);
    random_phase(130);
    set_top(10);
    random_phase(130);
    set_top(2);
    random_phase(110);
    set_top(7);
    random_phase(130);
    set_top(10);
    random_phase(120);

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d requests (%0d grants) over top orders 1 to 10.", n_items, n_grants);
    $display("Compared %0d result words, %0d errors.", board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timed out waiting for the allocator.");
    $display("FAILED: results differ");
    $finish;
  end
endmodule

`default_nettype wire

// ----- buddy_frame_allocator.f -----
+incdir+src
src/bfa_pkg.sv
src/buddy_frame_allocator.sv
bench/tb_buddy_frame_allocator.sv
